// ===== src/hvd_pkg.sv =====
// Shared types, constants and the arctangent table for the haversine distance block.
// Used by every module in src; depends on nothing else.
package hvd_pkg;

    localparam int CORDIC_STAGES_DEF = 24;

    // CORDIC datapath widths.
    localparam int XY_W  = 34;
    localparam int Z_W   = 33;
    localparam int ANG_W = 34;

    // Integer square root: 31 result bits from a 62-bit radicand.
    localparam int ROOT_W = 31;
    localparam int REM_W  = 62;

    localparam int RADIUS_W = 30;
    localparam logic [RADIUS_W-1:0] DEFAULT_RADIUS = 30'd417997586;

    // Angles in units of 2^-23 degree.
    localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd3019898880;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd1509949440;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd754974720;

    // Degrees-to-radians factor, split in two 17-bit halves for the multiply.
    localparam logic [63:0] DEG_TO_RAD_Q32 = 64'h3243F6A8885A308D / 64'd377487360;
    localparam logic [16:0] DEG_TO_RAD_HI  = DEG_TO_RAD_Q32[33:17];
    localparam logic [16:0] DEG_TO_RAD_LO  = DEG_TO_RAD_Q32[16:0];

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [Z_W-1:0]  z_t;

    function automatic logic [29:0] atan_q30(input int k);
        logic [29:0] r;
        unique case (k)
            0:  r = 30'd843314856;
            1:  r = 30'd497837829;
            2:  r = 30'd263043836;
            3:  r = 30'd133525158;
            4:  r = 30'd67021686;
            5:  r = 30'd33543515;
            6:  r = 30'd16775850;
            7:  r = 30'd8388437;
            8:  r = 30'd4194282;
            9:  r = 30'd2097149;
            10: r = 30'd1048575;
            11: r = 30'd524287;
            12: r = 30'd262143;
            13: r = 30'd131071;
            14: r = 30'd65535;
            15: r = 30'd32767;
            16: r = 30'd16383;
            17: r = 30'd8191;
            18: r = 30'd4095;
            19: r = 30'd2047;
            20: r = 30'd1023;
            21: r = 30'd511;
            22: r = 30'd255;
            23: r = 30'd127;
            24: r = 30'd63;
            25: r = 30'd31;
            26: r = 30'd15;
            27: r = 30'd8;
            28: r = 30'd4;
            29: r = 30'd2;
            30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/hvd_cordic_cell.sv =====
// One CORDIC iteration with its output registers, rotation or vectoring mode.
// Depends on hvd_pkg for widths and the arctangent table.
module hvd_cordic_cell
    import hvd_pkg::*;
#(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic aclk,
    input  logic en,
    input  xy_t  x_in,
    input  xy_t  y_in,
    input  z_t   z_in,
    output xy_t  x_out,
    output xy_t  y_out,
    output z_t   z_out
);

    localparam z_t ATAN = Z_W'(atan_q30(STAGE));

    xy_t x_next, y_next;
    z_t  z_next;
    xy_t x_reg, y_reg;
    z_t  z_reg;
    logic up;

    // Rotation turns toward z = 0, vectoring toward y = 0; both reduce to one rule.
    always_comb begin
        up = VECTORING ? y_in[XY_W-1] : ~z_in[Z_W-1];
        if (up) begin
            x_next = x_in - (y_in >>> STAGE);
            y_next = y_in + (x_in >>> STAGE);
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + (y_in >>> STAGE);
            y_next = y_in - (x_in >>> STAGE);
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== src/hvd_sqrt_cell.sv =====
// One result bit of a pipelined integer square root, with its registers.
// Depends on hvd_pkg for widths.
module hvd_sqrt_cell
    import hvd_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic [REM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out
);

    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_next, rem_reg;
    logic [ROOT_W-1:0] root_next, root_reg;

    // The remainder holds v - root^2; setting this bit costs 2^(b+1)*root + 2^(2b).
    always_comb begin
        trial = (REM_W'(root_in) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = root_in | (ROOT_W'(1) << BIT);
        end else begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== src/haversine_distance_top.sv =====
// Haversine great-circle distance, fully pipelined top level.
// Depends on hvd_pkg, hvd_cordic_cell and hvd_sqrt_cell.
//
// Usage: each input word carries two points (latitude and longitude in units
// of 2^-22 degree). One result word carries the distance in units of 2^-16 km.
// The sphere radius register is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle; the block itself does not
// enforce this. Reset loads the earth radius.
// The datapath is one long pipeline: five stages of angle reduction and
// degree-to-radian conversion, CORDIC_STAGES rotation cells, three product
// stages, 31 square-root cells, CORDIC_STAGES vectoring cells and two output
// stages. Throughput is one word per cycle while no low m_ready holds the
// output.
//
// The whole pipeline moves together. When the output word is held by a low
// m_ready the pipeline freezes and s_ready drops in the same cycle; a waiting
// output never blocks a word that is entering while the output is taken.
// Reset (aresetn low at a clock edge) empties the pipeline; no words are
// produced from work in flight.
module haversine_distance_top
    import hvd_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [RADIUS_W-1:0]  cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [29:0]   s_first_latitude,
    input  logic signed [30:0]   s_first_longitude,
    input  logic signed [29:0]   s_second_latitude,
    input  logic signed [30:0]   s_second_longitude,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_arc_distance
);

    localparam int N     = CORDIC_STAGES;
    localparam int DEPTH = 2 * N + 41;

    function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[31:0];
    endfunction

    logic                  en;
    logic [RADIUS_W-1:0]   radius_reg;
    logic [DEPTH-1:0]      valid_reg;

    logic signed [ANG_W-1:0] ang_reg  [4];
    logic signed [ANG_W-1:0] wrap_reg [4];
    logic [29:0]             mag_reg  [4];
    logic                    neg_a3_reg [4];
    logic                    neg_a4_reg [4];
    logic                    flip_a3_reg [4];
    logic                    flip_a4_reg [4];
    logic                    flip_a5_reg [4];
    logic [46:0]             ph_reg [4];
    logic [46:0]             pl_reg [4];
    logic                    flip_pipe_reg [N][4];

    xy_t rot_x [4][N+1];
    xy_t rot_y [4][N+1];
    z_t  rot_z [4][N+1];

    logic signed [31:0] sq_lat_reg, sq_lon_reg, cc_reg, sq_lat_p2_reg, term_reg;
    logic [30:0]        a_reg;
    logic signed [31:0] cos1, cos2;
    logic signed [32:0] a_sum;

    logic [REM_W-1:0]  sq_rem  [2][32];
    logic [ROOT_W-1:0] sq_root [2][32];

    xy_t vec_x [N+1];
    xy_t vec_y [N+1];
    z_t  vec_z [N+1];

    logic [60:0] prod_reg;
    logic [30:0] theta_pos;
    logic [61:0] dist_sum;
    logic [31:0] dist_reg;

    assign en      = ~valid_reg[DEPTH-1] | m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[DEPTH-1];
    assign m_arc_distance = dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= DEFAULT_RADIUS;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_valid};
        end
    end

    // Stage 1: differences and doubled latitudes, all in 2^-23 degree.
    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg[0] <= ANG_W'(s_second_latitude) - ANG_W'(s_first_latitude);
            ang_reg[1] <= ANG_W'(s_second_longitude) - ANG_W'(s_first_longitude);
            ang_reg[2] <= ANG_W'(s_first_latitude) <<< 1;
            ang_reg[3] <= ANG_W'(s_second_latitude) <<< 1;
        end
    end

    // Stage 2: wrap into (-180, 180]. Every input angle is within one turn.
    // Stage 3: fold into [-90, 90] and split sign from magnitude.
    for (genvar l = 0; l < 4; l++) begin : g_reduce
        logic signed [ANG_W-1:0] wrap_next, fold;
        logic                    flip_next;
        always_comb begin
            if (ang_reg[l] > HALF_TURN) begin
                wrap_next = ang_reg[l] - FULL_TURN;
            end else if (ang_reg[l] <= -HALF_TURN) begin
                wrap_next = ang_reg[l] + FULL_TURN;
            end else begin
                wrap_next = ang_reg[l];
            end
            if (wrap_reg[l] > QUARTER_TURN) begin
                fold      = HALF_TURN - wrap_reg[l];
                flip_next = 1'b1;
            end else if (wrap_reg[l] < -QUARTER_TURN) begin
                fold      = -HALF_TURN - wrap_reg[l];
                flip_next = 1'b1;
            end else begin
                fold      = wrap_reg[l];
                flip_next = 1'b0;
            end
        end

        logic signed [ANG_W-1:0] fold_abs;
        logic [63:0]             rad_sum;
        logic [31:0]             z_mag;
        assign fold_abs = fold[ANG_W-1] ? -fold : fold;
        assign rad_sum  = {ph_reg[l], 17'd0} + 64'(pl_reg[l]) + 64'h8000_0000;
        assign z_mag    = rad_sum[63:32];

        always_ff @(posedge aclk) begin
            if (en) begin
                wrap_reg[l]    <= wrap_next;
                mag_reg[l]     <= fold_abs[29:0];
                neg_a3_reg[l]  <= fold[ANG_W-1];
                flip_a3_reg[l] <= flip_next;
                ph_reg[l]      <= 47'(mag_reg[l]) * 47'(DEG_TO_RAD_HI);
                pl_reg[l]      <= 47'(mag_reg[l]) * 47'(DEG_TO_RAD_LO);
                neg_a4_reg[l]  <= neg_a3_reg[l];
                flip_a4_reg[l] <= flip_a3_reg[l];
                rot_z[l][0]    <= neg_a4_reg[l] ? -Z_W'(z_mag) : Z_W'(z_mag);
                rot_x[l][0]    <= CORDIC_GAIN_Q30;
                rot_y[l][0]    <= '0;
                flip_a5_reg[l] <= flip_a4_reg[l];
            end
        end

        for (genvar s = 0; s < N; s++) begin : g_rot
            hvd_cordic_cell #(.STAGE(s), .VECTORING(1'b0)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .x_in  (rot_x[l][s]),
                .y_in  (rot_y[l][s]),
                .z_in  (rot_z[l][s]),
                .x_out (rot_x[l][s+1]),
                .y_out (rot_y[l][s+1]),
                .z_out (rot_z[l][s+1])
            );
            if (s == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (en) begin
                        flip_pipe_reg[s][l] <= flip_a5_reg[l];
                    end
                end
            end else begin : g_rest
                always_ff @(posedge aclk) begin
                    if (en) begin
                        flip_pipe_reg[s][l] <= flip_pipe_reg[s-1][l];
                    end
                end
            end
        end
    end

    // Product stages: squares and cosine product, then the cross term, then a.
    always_comb begin
        cos1  = flip_pipe_reg[N-1][2] ? -rot_x[2][N][31:0] : rot_x[2][N][31:0];
        cos2  = flip_pipe_reg[N-1][3] ? -rot_x[3][N][31:0] : rot_x[3][N][31:0];
        a_sum = 33'(sq_lat_p2_reg) + 33'(term_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_lat_reg    <= round_q30(64'(rot_y[0][N]) * 64'(rot_y[0][N]));
            sq_lon_reg    <= round_q30(64'(rot_y[1][N]) * 64'(rot_y[1][N]));
            cc_reg        <= round_q30(64'(cos1) * 64'(cos2));
            sq_lat_p2_reg <= sq_lat_reg;
            term_reg      <= round_q30(64'(cc_reg) * 64'(sq_lon_reg));
            if (a_sum[32]) begin
                a_reg <= '0;
            end else if (a_sum > 33'sd1073741824) begin
                a_reg <= 31'd1073741824;
            end else begin
                a_reg <= a_sum[30:0];
            end
        end
    end

    // Square roots of a and 1 - a, both scaled by 2^30, one bit per cell.
    assign sq_rem[0][0]  = {1'b0, a_reg, 30'd0};
    assign sq_rem[1][0]  = {1'b0, 31'd1073741824 - a_reg, 30'd0};
    assign sq_root[0][0] = '0;
    assign sq_root[1][0] = '0;

    for (genvar r = 0; r < 2; r++) begin : g_sqrt
        for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
            hvd_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_cell (
                .aclk     (aclk),
                .en       (en),
                .rem_in   (sq_rem[r][j]),
                .root_in  (sq_root[r][j]),
                .rem_out  (sq_rem[r][j+1]),
                .root_out (sq_root[r][j+1])
            );
        end
    end

    // Vectoring CORDIC gives the half angle theta = atan2(sqrt(a), sqrt(1-a)).
    assign vec_x[0] = XY_W'(sq_root[1][ROOT_W]);
    assign vec_y[0] = XY_W'(sq_root[0][ROOT_W]);
    assign vec_z[0] = '0;

    for (genvar s = 0; s < N; s++) begin : g_vec
        hvd_cordic_cell #(.STAGE(s), .VECTORING(1'b1)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_in  (vec_x[s]),
            .y_in  (vec_y[s]),
            .z_in  (vec_z[s]),
            .x_out (vec_x[s+1]),
            .y_out (vec_y[s+1]),
            .z_out (vec_z[s+1])
        );
    end

    // Distance = radius * 2*theta, in 2^-16 km after rounding; saturates.
    always_comb begin
        theta_pos = vec_z[N][Z_W-1] ? '0 : vec_z[N][30:0];
        dist_sum  = 62'(prod_reg) + 62'h1000_0000;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 61'(radius_reg) * 61'(theta_pos);
            dist_reg <= dist_sum[61] ? 32'hFFFF_FFFF : dist_sum[60:29];
        end
    end

endmodule
